// File: rtl/core/pit_pkg.sv
// Shared constants and types of the point-in-torus test core.
// Depends on nothing; imported by the top level, pit_rotate and pit_test.
package pit_pkg;

    localparam int RAD_W      = 20;            // radius registers, unsigned Q8.12
    localparam int RAD_SQ_W   = 2 * RAD_W;     // squared radius
    localparam int ROT_W      = 18;            // rotation coefficient, signed Q1.16
    localparam int ROT_FRAC   = 16;
    localparam int CENTER_W   = 60;
    localparam int ROW_W      = 3 * ROT_W;
    localparam int CFG_DATA_W = 60;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [ROT_W-1:0] rot_coef_t;
    typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

    localparam cfg_idx_t CFG_CENTER    = 3'd0;
    localparam cfg_idx_t CFG_ROT_ROW_X = 3'd1;
    localparam cfg_idx_t CFG_ROT_ROW_Y = 3'd2;
    localparam cfg_idx_t CFG_ROT_ROW_Z = 3'd3;
    localparam cfg_idx_t CFG_MAJOR     = 3'd4;
    localparam cfg_idx_t CFG_MINOR     = 3'd5;

    // Identity matrix and unit major radius after reset.
    localparam logic [ROW_W-1:0]    ROT_ROW_X_RST = ROW_W'(65536);
    localparam logic [ROW_W-1:0]    ROT_ROW_Y_RST = ROW_W'(65536) << ROT_W;
    localparam logic [ROW_W-1:0]    ROT_ROW_Z_RST = ROW_W'(65536) << (2 * ROT_W);
    localparam logic [CENTER_W-1:0] CENTER_RST    = '0;
    localparam logic [RAD_W-1:0]    MAJOR_RST     = RAD_W'(4096);
    localparam logic [RAD_W-1:0]    MINOR_RST     = '0;

endpackage

// File: rtl/core/point_in_torus_test_core.sv
// Top level of the point-in-torus test core: configuration registers, radius squares,
// and the rotate and test pipelines. Depends on pit_pkg, pit_wide_mul, pit_rotate, pit_test.
//
// One point goes in per transfer and one flag comes out per transfer, in order. The core
// is a twelve-stage pipeline (four stages translate and rotate, eight square, sum,
// subtract and compare) and takes a new point in every cycle in which s_tready is high;
// its depth is set by the rotate and test pipelines, whose widest step is a multiplier
// split into four partial products over two stages. Each stage holds its item when the
// stage after it is full and stalled, so bubbles close up and a stalled output does not
// stop points from entering empty stages. The result is 1 when the point, after
// subtracting the center and rotating by the configured matrix (rotated coordinates
// floored after the Q1.16 scaling), lies strictly inside the torus; points on the
// surface give 0, and a zero minor radius gives 0 for every point. Write registers
// only while the core is empty; R^2 and r^2 follow a write through the partial-product
// and sum registers of their multipliers.
module point_in_torus_test_core
    import pit_pkg::*;
#(
    parameter int COORD_WIDTH = 20,
    localparam int S_DATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // point input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // point_x, point_y, point_z, zero pad
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata    // is_inside, zero pad
);

    localparam int CEN_W = (3 * COORD_WIDTH > CENTER_W) ? 3 * COORD_WIDTH : CENTER_W;

    logic [CENTER_W-1:0] center_reg;
    logic [ROW_W-1:0]    rot_row_reg [3];
    logic [RAD_W-1:0]    major_reg;
    logic [RAD_W-1:0]    minor_reg;

    logic [CEN_W-1:0]             cen_ext;
    logic signed [COORD_WIDTH-1:0] pt  [3];
    logic signed [COORD_WIDTH-1:0] cen [3];
    rot_coef_t                     coef [3][3];

    logic [RAD_SQ_W-1:0]    big_r2, small_r2;
    logic                   rot_valid, rot_ready;
    logic [COORD_WIDTH+2:0] mag [3];
    logic                   is_inside;

    // Register writes; indexes past the last register are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg     <= CENTER_RST;
            rot_row_reg[0] <= ROT_ROW_X_RST;
            rot_row_reg[1] <= ROT_ROW_Y_RST;
            rot_row_reg[2] <= ROT_ROW_Z_RST;
            major_reg      <= MAJOR_RST;
            minor_reg      <= MINOR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CENTER:    center_reg     <= cfg_wdata[CENTER_W-1:0];
                CFG_ROT_ROW_X: rot_row_reg[0] <= cfg_wdata[ROW_W-1:0];
                CFG_ROT_ROW_Y: rot_row_reg[1] <= cfg_wdata[ROW_W-1:0];
                CFG_ROT_ROW_Z: rot_row_reg[2] <= cfg_wdata[ROW_W-1:0];
                CFG_MAJOR:     major_reg      <= cfg_wdata[RAD_W-1:0];
                CFG_MINOR:     minor_reg      <= cfg_wdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the point, the center fields (zero beyond the register) and the matrix.
    always_comb begin
        cen_ext = CEN_W'(center_reg);
        for (int k = 0; k < 3; k++) begin
            pt[k]  = $signed(s_tdata[k*COORD_WIDTH +: COORD_WIDTH]);
            cen[k] = $signed(cen_ext[k*COORD_WIDTH +: COORD_WIDTH]);
        end
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                coef[j][k] = $signed(rot_row_reg[j][k*ROT_W +: ROT_W]);
            end
        end
    end

    // Radius squares track the registers; always enabled.
    pit_wide_mul #(.A_W(RAD_W), .B_W(RAD_W)) u_big_r2 (
        .aclk   (aclk),
        .en_pp  (1'b1),
        .en_sum (1'b1),
        .a      (major_reg),
        .b      (major_reg),
        .prod   (big_r2)
    );

    pit_wide_mul #(.A_W(RAD_W), .B_W(RAD_W)) u_small_r2 (
        .aclk   (aclk),
        .en_pp  (1'b1),
        .en_sum (1'b1),
        .a      (minor_reg),
        .b      (minor_reg),
        .prod   (small_r2)
    );

    pit_rotate #(.COORD_WIDTH(COORD_WIDTH)) u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .pt        (pt),
        .cen       (cen),
        .coef      (coef),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .mag       (mag)
    );

    pit_test #(.COORD_WIDTH(COORD_WIDTH)) u_test (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .mag       (mag),
        .big_r2    (big_r2),
        .small_r2  (small_r2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .is_inside (is_inside)
    );

    assign m_tdata = {7'b0, is_inside};

endmodule

// File: rtl/core/pit_wide_mul.sv
// Two-stage unsigned multiplier built from four half-width partial products.
// Stand-alone; used by pit_test and the top level.
module pit_wide_mul #(
    parameter int A_W = 24,
    parameter int B_W = 24
) (
    input  logic               aclk,
    input  logic               en_pp,
    input  logic               en_sum,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] prod
);

    localparam int A_LO = (A_W + 1) / 2;
    localparam int A_HI = A_W - A_LO;
    localparam int B_LO = (B_W + 1) / 2;
    localparam int B_HI = B_W - B_LO;
    localparam int P_W  = A_W + B_W;

    logic [A_LO+B_LO-1:0] ll_reg, ll_next;
    logic [A_LO+B_HI-1:0] lh_reg, lh_next;
    logic [A_HI+B_LO-1:0] hl_reg, hl_next;
    logic [A_HI+B_HI-1:0] hh_reg, hh_next;
    logic [P_W-1:0]       prod_reg, prod_next;

    always_comb begin
        ll_next = (A_LO+B_LO)'(a[A_LO-1:0]) * (A_LO+B_LO)'(b[B_LO-1:0]);
        lh_next = (A_LO+B_HI)'(a[A_LO-1:0]) * (A_LO+B_HI)'(b[B_W-1:B_LO]);
        hl_next = (A_HI+B_LO)'(a[A_W-1:A_LO]) * (A_HI+B_LO)'(b[B_LO-1:0]);
        hh_next = (A_HI+B_HI)'(a[A_W-1:A_LO]) * (A_HI+B_HI)'(b[B_W-1:B_LO]);
        prod_next = (P_W'(hh_reg) << (A_LO + B_LO)) + (P_W'(hl_reg) << A_LO)
                  + (P_W'(lh_reg) << B_LO) + P_W'(ll_reg);
    end

    always_ff @(posedge aclk) begin
        if (en_pp) begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
        end
        if (en_sum) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// File: rtl/core/pit_rotate.sv
// Translate and rotate stages: point minus center, matrix products, floor shift,
// magnitude. Four register stages. Depends on pit_pkg.
module pit_rotate
    import pit_pkg::*;
#(
    parameter int COORD_WIDTH = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] pt  [3],
    input  logic signed [COORD_WIDTH-1:0] cen [3],
    input  rot_coef_t                     coef [3][3],
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [COORD_WIDTH+2:0]        mag [3]
);

    localparam int D_W   = COORD_WIDTH + 1;
    localparam int PR_W  = D_W + ROT_W;
    localparam int SUM_W = PR_W + 2;
    localparam int RC_W  = COORD_WIDTH + 4;
    localparam int MAG_W = COORD_WIDTH + 3;
    localparam int NSTG  = 4;

    logic [NSTG-1:0] v_reg, v_next, en;

    logic signed [D_W-1:0]   d_reg    [3];
    logic signed [D_W-1:0]   d_next   [3];
    logic signed [PR_W-1:0]  prod_reg [3][3];
    logic signed [PR_W-1:0]  prod_next[3][3];
    logic signed [SUM_W-1:0] sum      [3];
    logic signed [SUM_W-1:0] sum_sh   [3];
    logic signed [RC_W-1:0]  rc_reg   [3];
    logic signed [RC_W-1:0]  rc_next  [3];
    logic [MAG_W-1:0]        mag_reg  [3];
    logic [MAG_W-1:0]        mag_next [3];

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        en[NSTG-1] = !v_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int i = 1; i < NSTG; i++) begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d_next[k] = $signed({pt[k][COORD_WIDTH-1], pt[k]})
                      - $signed({cen[k][COORD_WIDTH-1], cen[k]});
        end
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                prod_next[j][k] = PR_W'(coef[j][k]) * PR_W'(d_reg[k]);
            end
        end
        // Arithmetic shift gives the floor of the scaled sum.
        for (int j = 0; j < 3; j++) begin
            sum[j]     = SUM_W'(prod_reg[j][0]) + SUM_W'(prod_reg[j][1])
                       + SUM_W'(prod_reg[j][2]);
            sum_sh[j]  = sum[j] >>> ROT_FRAC;
            rc_next[j] = $signed(sum_sh[j][RC_W-1:0]);
            mag_next[j] = rc_reg[j][RC_W-1] ? MAG_W'(-rc_reg[j]) : MAG_W'(rc_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) d_reg    <= d_next;
        if (en[1]) prod_reg <= prod_next;
        if (en[2]) rc_reg   <= rc_next;
        if (en[3]) mag_reg  <= mag_next;
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NSTG-1];
    assign mag       = mag_reg;

endmodule

// File: rtl/core/pit_test.sv
// Inside test stages: squares, sums, subtract of r^2, then A^2 against 4R^2 s.
// Eight register stages, the last is the output register. Depends on pit_pkg, pit_wide_mul.
module pit_test
    import pit_pkg::*;
#(
    parameter int COORD_WIDTH = 20
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_WIDTH+2:0] mag [3],
    input  logic [RAD_SQ_W-1:0]    big_r2,
    input  logic [RAD_SQ_W-1:0]    small_r2,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   is_inside
);

    localparam int MAG_W = COORD_WIDTH + 3;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int S_W   = SQ_W + 1;
    localparam int Q_W   = ((SQ_W > RAD_SQ_W) ? SQ_W : RAD_SQ_W) + 1;
    localparam int P_W   = ((S_W > Q_W) ? S_W : Q_W) + 1;
    localparam int LHS_W = 2 * P_W;
    localparam int RHS_W = RAD_SQ_W + S_W;
    localparam int CMP_W = (LHS_W > RHS_W + 2) ? LHS_W : RHS_W + 2;
    localparam int NSTG  = 8;

    logic [NSTG-1:0] v_reg, v_next, en;

    logic [SQ_W-1:0]  sq [3];
    logic [S_W-1:0]   s2_reg, s2_next, s3_reg, s4_reg;
    logic [Q_W-1:0]   q2_reg, q2_next;
    logic [P_W-1:0]   p3_reg, p3_next;
    logic [P_W:0]     diff;
    logic [P_W-1:0]   a4_reg;
    logic             lt4_reg, lt5_reg, lt6_reg;
    logic [LHS_W-1:0] lhs;
    logic [RHS_W-1:0] rhs;
    logic [CMP_W-1:0] lhs_ext, rhs_ext;
    logic             inside_reg, inside_next;

    always_comb begin
        en[NSTG-1] = !v_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int i = 1; i < NSTG; i++) begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_sq
        pit_wide_mul #(.A_W(MAG_W), .B_W(MAG_W)) u_sq (
            .aclk   (aclk),
            .en_pp  (en[0]),
            .en_sum (en[1]),
            .a      (mag[k]),
            .b      (mag[k]),
            .prod   (sq[k])
        );
    end

    pit_wide_mul #(.A_W(P_W), .B_W(P_W)) u_lhs (
        .aclk   (aclk),
        .en_pp  (en[5]),
        .en_sum (en[6]),
        .a      (a4_reg),
        .b      (a4_reg),
        .prod   (lhs)
    );

    pit_wide_mul #(.A_W(RAD_SQ_W), .B_W(S_W)) u_rhs (
        .aclk   (aclk),
        .en_pp  (en[5]),
        .en_sum (en[6]),
        .a      (big_r2),
        .b      (s4_reg),
        .prod   (rhs)
    );

    always_comb begin
        s2_next = S_W'(sq[0]) + S_W'(sq[1]);
        q2_next = Q_W'(sq[2]) + Q_W'(big_r2);
        p3_next = P_W'(s2_reg) + P_W'(q2_reg);
        // Borrow out of p - r^2 means A < 0: inside regardless of the rest.
        diff    = {1'b0, p3_reg} - (P_W+1)'(small_r2);
        lhs_ext = CMP_W'(lhs);
        rhs_ext = CMP_W'(rhs) << 2;
        inside_next = lt6_reg || (lhs_ext < rhs_ext);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s2_reg <= s2_next;
            q2_reg <= q2_next;
        end
        if (en[3]) begin
            p3_reg <= p3_next;
            s3_reg <= s2_reg;
        end
        if (en[4]) begin
            a4_reg  <= diff[P_W-1:0];
            lt4_reg <= diff[P_W];
            s4_reg  <= s3_reg;
        end
        if (en[5]) lt5_reg <= lt4_reg;
        if (en[6]) lt6_reg <= lt5_reg;
        if (en[7]) inside_reg <= inside_next;
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NSTG-1];
    assign is_inside = inside_reg;

endmodule
